[design/cpq_pkg.sv]
// Shared types and constants for the convex polygon point query block.
package cpq_pkg;

    // Command codes carried on the input beat's tuser
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    // Result count fields are 5 bits wide, counts above that wrap
    localparam int CNT_OUT_W = 5;
    typedef logic [CNT_OUT_W-1:0] cnt_out_t;

    // Result beat: inside, nearest edge, vertex total, dropped, padded to 16
    localparam int OUT_USED_W = 2 + 2 * CNT_OUT_W;
    localparam int OUT_DW     = 16;

    // Smallest vertex count that makes a polygon
    localparam int MIN_CORNERS = 3;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic read;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic enough;
        logic read_last;
        logic busy;
        logic out_free;
    } dp_sts_t;

endpackage

[design/cpq_ctrl.sv]
// Controller state machine for the convex polygon point query block.
module cpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_kind,
    output logic                in_ready,
    input  cpq_pkg::dp_sts_t    sts,
    output cpq_pkg::ctrl_cmd_t  cmd
);

    cpq_pkg::state_t state_reg;
    cpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            cpq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_kind)
                        cpq_pkg::CMD_CLEAR:  cmd.clear  = 1'b1;
                        cpq_pkg::CMD_APPEND: cmd.append = 1'b1;
                        cpq_pkg::CMD_QUERY:
                        begin
                            cmd.start  = 1'b1;
                            // too few vertices: skip the edge walk
                            state_next = sts.enough ? cpq_pkg::ST_WALK : cpq_pkg::ST_DRAIN;
                        end
                        default: state_next = cpq_pkg::ST_IDLE;
                    endcase
                end
            end
            cpq_pkg::ST_WALK:
            begin
                cmd.read = 1'b1;
                if (sts.read_last)
                begin
                    state_next = cpq_pkg::ST_DRAIN;
                end
            end
            cpq_pkg::ST_DRAIN:
            begin
                if (!sts.busy && sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = cpq_pkg::ST_IDLE;
                end
            end
            default: state_next = cpq_pkg::ST_IDLE;
        endcase
    end

endmodule

[design/cpq_cmp.sv]
// Exact compare of two squared distances as ratios: a_sq/a_len < b_sq/b_len.
module cpq_cmp #(
    parameter int HALF_W = 21,
    parameter int LEN_W  = 21
) (
    input  logic                  clk,
    input  logic [2*HALF_W-1:0]   a_sq,
    input  logic [LEN_W-1:0]      a_len,
    input  logic [2*HALF_W-1:0]   b_sq,
    input  logic [LEN_W-1:0]      b_len,
    output logic                  a_lt_b
);

    localparam int PPW  = HALF_W + LEN_W;
    localparam int SUMW = 2 * HALF_W + LEN_W;

    logic [PPW-1:0]  al_reg;
    logic [PPW-1:0]  ah_reg;
    logic [PPW-1:0]  bl_reg;
    logic [PPW-1:0]  bh_reg;
    logic [SUMW-1:0] lhs;
    logic [SUMW-1:0] rhs;

    // split partial products, a_sq*b_len vs b_sq*a_len
    always_ff @(posedge clk)
    begin
        al_reg <= PPW'(a_sq[HALF_W-1:0]) * PPW'(b_len);
        ah_reg <= PPW'(a_sq[2*HALF_W-1:HALF_W]) * PPW'(b_len);
        bl_reg <= PPW'(b_sq[HALF_W-1:0]) * PPW'(a_len);
        bh_reg <= PPW'(b_sq[2*HALF_W-1:HALF_W]) * PPW'(a_len);
    end

    assign lhs    = (SUMW'(ah_reg) << HALF_W) + SUMW'(al_reg);
    assign rhs    = (SUMW'(bh_reg) << HALF_W) + SUMW'(bl_reg);
    assign a_lt_b = lhs < rhs;

endmodule

[design/cpq_dp.sv]
// Datapath: vertex store, edge pipeline, nearest edge tracking and result register.
module cpq_dp #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cpq_pkg::ctrl_cmd_t           cmd,
    output cpq_pkg::dp_sts_t             sts,
    input  logic [COORD_BITS-1:0]        pos_x,
    input  logic [COORD_BITS-1:0]        pos_y,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [cpq_pkg::OUT_DW-1:0]   out_data
);

    localparam int C    = COORD_BITS;
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int DW   = C + 1;          // coordinate difference
    localparam int PW   = 2 * C + 2;      // difference product
    localparam int CW   = 2 * C + 3;      // cross, dot, length sums
    localparam int MW   = 2 * C + 1;      // |cross|
    localparam int LW   = 2 * C + 1;      // squared edge length
    localparam int SW   = 2 * MW;         // cross squared

    // vertex store, {y, x} per entry
    logic [2*C-1:0] mem [MAX_VERTICES];

    logic [CNTW-1:0] count_reg;
    logic            ovf_reg;
    logic [C-1:0]    px_reg;
    logic [C-1:0]    py_reg;

    // read stage
    logic [CNTW-1:0] rd_pos_reg;
    logic [AW-1:0]   rd_addr;
    logic            rd_v_reg;
    logic            rd_first_reg;
    logic [CNTW-1:0] rd_idx_reg;
    logic [2*C-1:0]  rd_word_reg;
    logic [2*C-1:0]  prev_word_reg;

    // differences
    logic                 d_v_reg;
    logic [CNTW-1:0]      d_idx_reg;
    logic signed [DW-1:0] vx_reg;
    logic signed [DW-1:0] vy_reg;
    logic signed [DW-1:0] ex_reg;
    logic signed [DW-1:0] ey_reg;

    // products
    logic                 m_v_reg;
    logic [CNTW-1:0]      m_idx_reg;
    logic signed [PW-1:0] p_vxey_reg;
    logic signed [PW-1:0] p_exvy_reg;
    logic signed [PW-1:0] p_vxex_reg;
    logic signed [PW-1:0] p_vyey_reg;
    logic signed [PW-1:0] p_exex_reg;
    logic signed [PW-1:0] p_eyey_reg;

    // sums
    logic                 s_v_reg;
    logic [CNTW-1:0]      s_idx_reg;
    logic signed [CW-1:0] s_cross_reg;
    logic signed [CW-1:0] s_dot_reg;
    logic signed [CW-1:0] s_len_reg;

    // qualify
    logic            q_v_reg;
    logic            q_qual_reg;
    logic [CNTW-1:0] q_idx_reg;
    logic [MW-1:0]   q_mag_reg;
    logic [LW-1:0]   q_len_reg;

    // cross squared
    logic            r_v_reg;
    logic            r_qual_reg;
    logic [CNTW-1:0] r_idx_reg;
    logic [SW-1:0]   r_sq_reg;
    logic [LW-1:0]   r_len_reg;

    // compare stage candidate
    logic            c_v_reg;
    logic            c_qual_reg;
    logic [CNTW-1:0] c_idx_reg;
    logic [SW-1:0]   c_sq_reg;
    logic [LW-1:0]   c_len_reg;

    logic [CNTW-1:0] best_idx_reg;
    logic [SW-1:0]   best_sq_reg;
    logic [LW-1:0]   best_len_reg;
    logic            last_won_reg;
    logic            inside_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [cpq_pkg::OUT_DW-1:0] out_data_reg;

    logic lt_best;
    logic lt_prev;
    logic win;
    logic has_room;
    logic enough;

    assign has_room = count_reg < CNTW'(MAX_VERTICES);
    assign enough   = count_reg >= CNTW'(cpq_pkg::MIN_CORNERS);
    // last read wraps to vertex 0 to close the polygon
    assign rd_addr  = (rd_pos_reg == count_reg) ? '0 : rd_pos_reg[AW-1:0];

    // candidate vs running best, and vs the edge one step ahead
    cpq_cmp #(.HALF_W(MW), .LEN_W(LW)) u_cmp_best (
        .clk    (clk),
        .a_sq   (r_sq_reg),
        .a_len  (r_len_reg),
        .b_sq   (best_sq_reg),
        .b_len  (best_len_reg),
        .a_lt_b (lt_best)
    );

    cpq_cmp #(.HALF_W(MW), .LEN_W(LW)) u_cmp_prev (
        .clk    (clk),
        .a_sq   (r_sq_reg),
        .a_len  (r_len_reg),
        .b_sq   (c_sq_reg),
        .b_len  (c_len_reg),
        .a_lt_b (lt_prev)
    );

    // if the previous edge just took the best slot, its direct compare applies
    assign win = c_v_reg && c_qual_reg &&
                 ((best_idx_reg == '0) || (last_won_reg ? lt_prev : lt_best));

    assign out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_pos_reg    <= '0;
            rd_v_reg      <= 1'b0;
            d_v_reg       <= 1'b0;
            m_v_reg       <= 1'b0;
            s_v_reg       <= 1'b0;
            q_v_reg       <= 1'b0;
            r_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            best_idx_reg  <= '0;
            last_won_reg  <= 1'b0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.append)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (cmd.start)
            begin
                rd_pos_reg <= '0;
            end
            else if (cmd.read)
            begin
                rd_pos_reg <= rd_pos_reg + 1'b1;
            end

            rd_v_reg <= cmd.read;
            d_v_reg  <= rd_v_reg && !rd_first_reg;
            m_v_reg  <= d_v_reg;
            s_v_reg  <= m_v_reg;
            q_v_reg  <= s_v_reg;
            r_v_reg  <= q_v_reg;
            c_v_reg  <= r_v_reg;

            if (cmd.start)
            begin
                best_idx_reg <= '0;
                last_won_reg <= 1'b0;
                inside_reg   <= enough;
            end
            else
            begin
                last_won_reg <= win;
                if (win)
                begin
                    best_idx_reg <= c_idx_reg;
                end
                if (s_v_reg && s_cross_reg[CW-1])
                begin
                    inside_reg <= 1'b0;
                end
            end

            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && has_room)
        begin
            mem[count_reg[AW-1:0]] <= {pos_y, pos_x};
        end
        if (cmd.start)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
        if (cmd.read)
        begin
            rd_word_reg  <= mem[rd_addr];
            rd_first_reg <= (rd_pos_reg == '0);
            rd_idx_reg   <= rd_pos_reg;
        end
        if (rd_v_reg)
        begin
            prev_word_reg <= rd_word_reg;
        end

        // edge runs from the previous vertex to the one just read
        d_idx_reg <= rd_idx_reg;
        vx_reg <= $signed(DW'(px_reg)) - $signed(DW'(prev_word_reg[C-1:0]));
        vy_reg <= $signed(DW'(py_reg)) - $signed(DW'(prev_word_reg[2*C-1:C]));
        ex_reg <= $signed(DW'(rd_word_reg[C-1:0])) - $signed(DW'(prev_word_reg[C-1:0]));
        ey_reg <= $signed(DW'(rd_word_reg[2*C-1:C])) - $signed(DW'(prev_word_reg[2*C-1:C]));

        m_idx_reg  <= d_idx_reg;
        p_vxey_reg <= PW'(vx_reg) * PW'(ey_reg);
        p_exvy_reg <= PW'(ex_reg) * PW'(vy_reg);
        p_vxex_reg <= PW'(vx_reg) * PW'(ex_reg);
        p_vyey_reg <= PW'(vy_reg) * PW'(ey_reg);
        p_exex_reg <= PW'(ex_reg) * PW'(ex_reg);
        p_eyey_reg <= PW'(ey_reg) * PW'(ey_reg);

        s_idx_reg   <= m_idx_reg;
        s_cross_reg <= CW'(p_vxey_reg) - CW'(p_exvy_reg);
        s_dot_reg   <= CW'(p_vxex_reg) + CW'(p_vyey_reg);
        s_len_reg   <= CW'(p_exex_reg) + CW'(p_eyey_reg);

        // projection within the segment, non-degenerate edge
        q_idx_reg  <= s_idx_reg;
        q_qual_reg <= (s_len_reg != '0) && !s_dot_reg[CW-1] && (s_dot_reg <= s_len_reg);
        q_mag_reg  <= s_cross_reg[CW-1] ? MW'(-s_cross_reg) : MW'(s_cross_reg);
        q_len_reg  <= s_len_reg[LW-1:0];

        r_idx_reg  <= q_idx_reg;
        r_qual_reg <= q_qual_reg;
        r_sq_reg   <= SW'(q_mag_reg) * SW'(q_mag_reg);
        r_len_reg  <= q_len_reg;

        c_idx_reg  <= r_idx_reg;
        c_qual_reg <= r_qual_reg;
        c_sq_reg   <= r_sq_reg;
        c_len_reg  <= r_len_reg;

        if (win)
        begin
            best_sq_reg  <= c_sq_reg;
            best_len_reg <= c_len_reg;
        end

        if (cmd.load)
        begin
            out_data_reg <= {{(cpq_pkg::OUT_DW - cpq_pkg::OUT_USED_W){1'b0}},
                             ovf_reg,
                             cpq_pkg::cnt_out_t'(count_reg),
                             cpq_pkg::cnt_out_t'(best_idx_reg),
                             inside_reg};
        end
    end

    assign sts.enough    = enough;
    assign sts.read_last = rd_pos_reg == count_reg;
    assign sts.busy      = rd_v_reg || d_v_reg || m_v_reg || s_v_reg ||
                           q_v_reg || r_v_reg || c_v_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/convex_polygon_point_query_top.sv]
// Top level of the convex polygon point query block.
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: pos_x, pos_y
//  m_axis   | out       | tdata: inside_res, nearest_edge, vertex_total, dropped
//
// Clear, append and unused commands give no result. A query with N >= 3
// vertices makes N + 1 vertex reads that feed an edge pipeline one edge a
// cycle; when the seven pipeline stages have drained and m_axis is free,
// the result is loaded. With fewer than three vertices a query skips the
// vertex walk.
// Reset (rst_n low, asynchronous) empties the polygon and the overflow flag;
// vertex storage is not cleared, and no clearing pass runs.
// Input is taken only while no query runs; a finished result held on m_axis
// does not block clears and appends, only the load of the next query result.
module convex_polygon_point_query_top #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [COORD_BITS-1:0] pos_x, [2*COORD_BITS-1:COORD_BITS] pos_y, zero pad above
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                   s_axis_tuser,

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [0] inside_res, [5:1] nearest_edge, [10:6] vertex_total, [11] dropped,
    // [15:12] zero
    output logic [cpq_pkg::OUT_DW-1:0]   m_axis_tdata
);

    cpq_pkg::ctrl_cmd_t cmd;
    cpq_pkg::dp_sts_t   sts;

    // sequencing: accept, vertex walk, pipeline drain, result load
    cpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // vertex store, edge arithmetic, nearest edge tracking, output register
    cpq_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .pos_x     (s_axis_tdata[COORD_BITS-1:0]),
        .pos_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

[design/cpq_chk.sv]
// Port-level checks for the convex polygon point query block, bound to the top level.
module cpq_chk #(
    parameter int MAX_VERTICES = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [1:0]                 s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [cpq_pkg::OUT_DW-1:0] m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a query locks out the input for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == cpq_pkg::CMD_QUERY
        |=> !s_axis_tready)
        else $error("input taken right after a query");

    // only a query takes the input side out of ready
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tuser == cpq_pkg::CMD_QUERY))
        else $error("ready dropped without a query");

    // a dropped append means the list is full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11]
        |-> m_axis_tdata[10:6] == cpq_pkg::cnt_out_t'(MAX_VERTICES))
        else $error("dropped flag with a list that is not full");

    // an inside hit or an edge index needs a real polygon and a valid index
    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[5:1] != 5'd0)
        |-> (MAX_VERTICES > 31) ||
            (m_axis_tdata[10:6] >= 5'd3 && m_axis_tdata[5:1] <= m_axis_tdata[10:6]))
        else $error("result inconsistent with vertex count");

endmodule

bind convex_polygon_point_query_top cpq_chk #(
    .MAX_VERTICES (MAX_VERTICES)
) u_cpq_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_convex_polygon_point_query_top.sv]
// Self-checking testbench for the convex polygon point query block.
module tb_convex_polygon_point_query_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 10;
    localparam int IN_DW        = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

    // Command 3 is not in the package enum; the block must drop it silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Output hold-off length and no-progress limit. The longest legal quiet
    // spell is the hold-off plus one query walk plus a sender gap, so the
    // limit leaves a wide margin.
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    typedef logic [COORD_BITS-1:0] coord_t;

    // m_axis_tdata layout, lowest bit last in the list
    typedef struct packed {
        logic [cpq_pkg::OUT_DW-cpq_pkg::OUT_USED_W-1:0] pad;
        logic                                           dropped;
        cpq_pkg::cnt_out_t                              vertex_total;
        cpq_pkg::cnt_out_t                              nearest_edge;
        logic                                           inside_res;
    } query_answer_t;

    // Tracks the polygon as the block should hold it and checks each answer.
    class query_scoreboard;
        coord_t          corner_x[MAX_VERTICES];
        coord_t          corner_y[MAX_VERTICES];
        int unsigned     corners;
        bit              overflow;
        query_answer_t   expected_answers[$];
        int unsigned     mismatches;
        int unsigned     checked;
        int unsigned     inside_hits;
        int unsigned     edge_hits;
        int unsigned     dropped_hits;

        function new();
            corners      = 0;
            overflow     = 1'b0;
            mismatches   = 0;
            checked      = 0;
            inside_hits  = 0;
            edge_hits    = 0;
            dropped_hits = 0;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Inside test plus nearest on-segment edge, exact integer compare.
        function query_answer_t answer_query(coord_t qx, coord_t qy);
            query_answer_t ans;
            int unsigned   i;
            int unsigned   nxt;
            int unsigned   best;
            longint        ax, ay, vx, vy, ex, ey;
            longint        xprod, dot, len2, mag;
            longint        best_mag, best_len;
            logic [127:0]  lhs, rhs;
            ans      = '0;
            best     = 0;
            best_mag = 0;
            best_len = 1;
            if (corners >= cpq_pkg::MIN_CORNERS)
            begin
                ans.inside_res = 1'b1;
                for (i = 0; i < corners; i++)
                begin
                    nxt   = (i + 1 < corners) ? i + 1 : 0;
                    ax    = longint'(corner_x[i]);
                    ay    = longint'(corner_y[i]);
                    vx    = longint'(qx) - ax;
                    vy    = longint'(qy) - ay;
                    ex    = longint'(corner_x[nxt]) - ax;
                    ey    = longint'(corner_y[nxt]) - ay;
                    xprod = vx * ey - ex * vy;
                    dot   = vx * ex + vy * ey;
                    len2  = ex * ex + ey * ey;
                    if (xprod < 0)
                        ans.inside_res = 1'b0;
                    // degenerate edges never qualify; ties keep the earlier edge
                    if (len2 > 0 && dot >= 0 && dot <= len2)
                    begin
                        mag = (xprod < 0) ? -xprod : xprod;
                        lhs = 128'(mag) * 128'(mag) * 128'(best_len);
                        rhs = 128'(best_mag) * 128'(best_mag) * 128'(len2);
                        if (best == 0 || lhs < rhs)
                        begin
                            best     = i + 1;
                            best_mag = mag;
                            best_len = len2;
                        end
                    end
                end
            end
            ans.nearest_edge = cpq_pkg::cnt_out_t'(best);
            ans.vertex_total = cpq_pkg::cnt_out_t'(corners);
            ans.dropped      = overflow;
            return ans;
        endfunction

        function void note_command(logic [1:0] cmd, coord_t x, coord_t y);
            if (cmd == cpq_pkg::CMD_CLEAR)
            begin
                corners  = 0;
                overflow = 1'b0;
            end
            else if (cmd == cpq_pkg::CMD_APPEND)
            begin
                if (corners < MAX_VERTICES)
                begin
                    corner_x[corners] = x;
                    corner_y[corners] = y;
                    corners++;
                end
                else
                    overflow = 1'b1;
            end
            else if (cmd == cpq_pkg::CMD_QUERY)
                expected_answers.push_back(answer_query(x, y));
        endfunction

        task check_result(logic [cpq_pkg::OUT_DW-1:0] data);
            query_answer_t got;
            query_answer_t want;
            got = data;
            if (expected_answers.size() == 0)
            begin
                report_mismatch($sformatf("result beat 0x%h with no query outstanding", data));
                return;
            end
            want = expected_answers.pop_front();
            checked++;
            if (want.inside_res)        inside_hits++;
            if (want.nearest_edge != 0) edge_hits++;
            if (want.dropped)           dropped_hits++;
            if (got.inside_res !== want.inside_res)
                report_mismatch($sformatf("answer %0d inside_res %b, want %b",
                                          checked, got.inside_res, want.inside_res));
            if (got.nearest_edge !== want.nearest_edge)
                report_mismatch($sformatf("answer %0d nearest_edge %0d, want %0d",
                                          checked, got.nearest_edge, want.nearest_edge));
            if (got.vertex_total !== want.vertex_total)
                report_mismatch($sformatf("answer %0d vertex_total %0d, want %0d",
                                          checked, got.vertex_total, want.vertex_total));
            if (got.dropped !== want.dropped)
                report_mismatch($sformatf("answer %0d dropped %b, want %b",
                                          checked, got.dropped, want.dropped));
            if (got.pad !== '0)
                report_mismatch($sformatf("answer %0d pad bits 0x%h not zero",
                                          checked, got.pad));
        endtask

        function int pending();
            return expected_answers.size();
        endfunction

        task flag_leftovers();
            if (expected_answers.size() != 0)
                report_mismatch($sformatf("%0d query results never arrived",
                                          expected_answers.size()));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_DW-1:0] s_axis_tdata  = '0;   // pos_x low, pos_y above, zero pad
    logic [1:0]       s_axis_tuser  = '0;   // command
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [cpq_pkg::OUT_DW-1:0] m_axis_tdata;   // inside, nearest, total, dropped

    convex_polygon_point_query_top #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    query_scoreboard sb;

    // flow-control knobs, changed by the stimulus process between phases
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    bit          src_burst      = 1'b0;  // sender runs back to back for a while
    bit          hold_req       = 1'b0;  // asks the sink for one long hold-off
    int unsigned commands_sent  = 0;     // clear/append/query beats accepted
    int unsigned stall_cycles   = 0;

    // polygon currently being loaded, kept only to aim query points
    coord_t      poly_x[MAX_VERTICES];
    coord_t      poly_y[MAX_VERTICES];
    int          poly_n  = 0;
    int          poly_cx = 0;
    int          poly_cy = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge. The result check
    // runs first so a query accepted on the same edge queues behind the
    // answer that is leaving.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_command(s_axis_tuser, s_axis_tdata[COORD_BITS-1:0],
                                s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Result sink. Random stalls come in windows, some of them stall-free.
    // A hold-off request drops tready for HOLD_CYCLES, counted here, while
    // the sender keeps going.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        int unsigned window;
        bit          free_window;
        hold_left   = 0;
        window      = 0;
        free_window = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (window == 0)
                begin
                    window      = 40;
                    free_window = ($urandom_range(0, 3) == 0);
                end
                window--;
                m_axis_tready <= free_window || ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // One input beat. Drives at the falling edge, possibly after random idle
    // cycles, then holds until the rising edge that takes it. tvalid stays
    // high into the next call, so it never gets two updates in one step.
    task automatic send_beat(input logic [1:0] cmd, input coord_t x, input coord_t y);
        @(negedge clk);
        while (!src_burst && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_DW - 2 * COORD_BITS){1'b0}}, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cmd != CMD_UNUSED)
            commands_sent++;
    endtask

    function automatic coord_t clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        return coord_t'(v);
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(0, COORD_MAX));
    endfunction

    // Sender goes quiet until every expected answer is back.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Convex-ish polygon: jittered angles around a random center, either
    // winding. Clamping at the screen border can flatten or merge corners,
    // which brings in collinear and zero-length edges.
    task automatic make_polygon();
        int  pick;
        int  k;
        int  rad;
        real ang0;
        real a;
        bit  cw;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            poly_n = $urandom_range(0, cpq_pkg::MIN_CORNERS - 1);
        else if (pick < 5)
            poly_n = MAX_VERTICES;
        else if (pick < 14)
            poly_n = $urandom_range(cpq_pkg::MIN_CORNERS, 8);
        else
            poly_n = $urandom_range(9, MAX_VERTICES - 1);
        poly_cx = $urandom_range(0, COORD_MAX);
        poly_cy = $urandom_range(0, COORD_MAX);
        rad     = $urandom_range(4, 600);
        ang0    = $urandom_range(0, 999) * 6.283185307 / 1000.0;
        cw      = $urandom_range(0, 1);
        for (k = 0; k < poly_n; k++)
        begin
            a = ang0 + 6.283185307 * (k + $urandom_range(0, 70) / 100.0) / poly_n;
            if (cw)
                a = -a;
            poly_x[k] = clamp_coord(poly_cx + $rtoi(rad * $cos(a)));
            poly_y[k] = clamp_coord(poly_cy + $rtoi(rad * $sin(a)));
        end
    endtask

    // Query point aimed at the interesting spots of the loaded polygon.
    task automatic pick_query_point(output coord_t qx, output coord_t qy);
        int i;
        int j;
        int mode;
        mode = (poly_n == 0) ? 0 : $urandom_range(0, 5);
        i    = (poly_n == 0) ? 0 : $urandom_range(0, poly_n - 1);
        j    = (i + 1 < poly_n) ? i + 1 : 0;
        case (mode)
            1:
            begin
                qx = clamp_coord(poly_cx + $urandom_range(0, 8) - 4);
                qy = clamp_coord(poly_cy + $urandom_range(0, 8) - 4);
            end
            2:
            begin
                qx = poly_x[i];
                qy = poly_y[i];
            end
            3:
            begin
                qx = coord_t'((int'(poly_x[i]) + int'(poly_x[j])) / 2);
                qy = coord_t'((int'(poly_y[i]) + int'(poly_y[j])) / 2);
            end
            4:
            begin
                qx = clamp_coord(int'(poly_x[i]) + $urandom_range(0, 6) - 3);
                qy = clamp_coord(int'(poly_y[i]) + $urandom_range(0, 6) - 3);
            end
            5:
            begin
                qx = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
                qy = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
            end
            default:
            begin
                qx = any_coord();
                qy = any_coord();
            end
        endcase
    endtask

    // Directed opener: empty and tiny polygons, unused command, corner
    // coordinates, a duplicated corner and a four-way distance tie.
    task automatic run_directed();
        send_beat(cpq_pkg::CMD_QUERY,  10'd0,    10'd0);     // empty polygon
        send_beat(cpq_pkg::CMD_APPEND, 10'd0,    10'd0);
        send_beat(cpq_pkg::CMD_APPEND, 10'd1023, 10'd1023);
        send_beat(cpq_pkg::CMD_QUERY,  10'd512,  10'd512);   // two corners only
        send_beat(CMD_UNUSED,          10'd1023, 10'd1023);  // must be dropped
        send_beat(cpq_pkg::CMD_APPEND, 10'd0,    10'd1023);  // full-range triangle
        send_beat(cpq_pkg::CMD_QUERY,  10'd0,    10'd0);     // on a corner
        send_beat(cpq_pkg::CMD_QUERY,  10'd1023, 10'd0);
        send_beat(cpq_pkg::CMD_QUERY,  10'd100,  10'd900);
        send_beat(cpq_pkg::CMD_CLEAR,  10'd0,    10'd0);
        send_beat(cpq_pkg::CMD_APPEND, 10'd100,  10'd100);
        send_beat(cpq_pkg::CMD_APPEND, 10'd100,  10'd100);   // zero-length edge
        send_beat(cpq_pkg::CMD_APPEND, 10'd100,  10'd900);
        send_beat(cpq_pkg::CMD_APPEND, 10'd900,  10'd900);
        send_beat(cpq_pkg::CMD_APPEND, 10'd900,  10'd100);
        send_beat(cpq_pkg::CMD_QUERY,  10'd500,  10'd500);   // all sides equally near
        send_beat(cpq_pkg::CMD_QUERY,  10'd1023, 10'd1023);
        send_beat(cpq_pkg::CMD_QUERY,  10'd0,    10'd500);
        send_beat(cpq_pkg::CMD_QUERY,  10'd100,  10'd500);   // on an edge
        send_beat(cpq_pkg::CMD_CLEAR,  10'd1023, 10'd1023);
        send_beat(cpq_pkg::CMD_QUERY,  10'd1023, 10'd1023);  // after clear
    endtask

    // Random part: mostly clear / load polygon / query bursts, with some
    // unstructured noise beats. hold_at > 0 triggers the output hold-off
    // once that many commands have gone in.
    task automatic run_random(input int unsigned target, input int unsigned hold_at);
        int     k;
        int     nq;
        coord_t qx;
        coord_t qy;
        while (commands_sent < target)
        begin
            if (hold_at > 0 && commands_sent >= hold_at)
            begin
                hold_req = 1'b1;
                hold_at  = 0;
            end
            src_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_beat(2'($urandom_range(0, 3)), any_coord(), any_coord());
            end
            else
            begin
                make_polygon();
                // occasionally skip the clear so loads pile up on the old list
                if ($urandom_range(0, 9) != 0)
                    send_beat(cpq_pkg::CMD_CLEAR, any_coord(), any_coord());
                for (k = 0; k < poly_n; k++)
                    send_beat(cpq_pkg::CMD_APPEND, poly_x[k], poly_y[k]);
                if (poly_n >= MAX_VERTICES - 2 && $urandom_range(0, 1) == 0)
                    repeat ($urandom_range(1, 3))
                        send_beat(cpq_pkg::CMD_APPEND, any_coord(), any_coord());
                nq = $urandom_range(1, 6);
                for (k = 0; k < nq; k++)
                begin
                    pick_query_point(qx, qy);
                    send_beat(cpq_pkg::CMD_QUERY, qx, qy);
                end
            end
        end
        src_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // phase 1: no idling; one long output hold-off fills the block
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random(230, 90);
        // sender pauses until every answer is back
        wait_drained();

        // phase 2: sender idles about half the time
        src_idle_pct   = 50;
        sink_stall_pct = 0;
        run_random(440, 0);

        // phase 3: receiver stalls about half the time
        src_idle_pct   = 0;
        sink_stall_pct = 50;
        run_random(645, 0);

        // phase 4: both sides throttle
        src_idle_pct   = 26;
        sink_stall_pct = 26;
        run_random(850, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flag_leftovers();

        $display("Sent %0d commands across four flow-control phases with a %0d-cycle hold-off.",
                 commands_sent, HOLD_CYCLES);
        $display("Checked %0d answers: %0d inside, %0d with a nearest edge, %0d after overflow.",
                 sb.checked, sb.inside_hits, sb.edge_hits, sb.dropped_hits);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
design/cpq_pkg.sv
design/cpq_ctrl.sv
design/cpq_cmp.sv
design/cpq_dp.sv
design/convex_polygon_point_query_top.sv
design/cpq_chk.sv
verif/tb_convex_polygon_point_query_top.sv
